// ----- sv/hbt_pkg.sv -----
package hbt_pkg;

  localparam int ID_W    = 64;
  localparam int MS_W    = 32;
  localparam int LIMIT_W = 31;
  localparam int LIVE_W  = 5;

  typedef enum logic [1:0] {
    ACT_REGISTER   = 2'd0,
    ACT_UNREGISTER = 2'd1,
    ACT_ACTIVITY   = 2'd2,
    ACT_TICK       = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_EXPIRED = 2'd1,
    KIND_DONE    = 2'd2
  } kind_t;

  localparam logic REASON_HB_LOST = 1'b0;
  localparam logic REASON_IDLE    = 1'b1;

  localparam logic CFG_HEARTBEAT = 1'b0;
  localparam logic CFG_IDLE      = 1'b1;

  typedef struct packed {
    action_t          action;
    logic             is_tick;
    logic [ID_W-1:0]  conn_id;
    logic [MS_W-1:0]  now_ms;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } item_head_t;

  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   expired_id;
    logic              reason;
    logic              table_full;
    logic [LIVE_W-1:0] live_total;
    logic              last;
  } result_t;

endpackage

// ----- sv/hbt_if.sv -----
interface hbt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] conn_id;
  logic [31:0] now_ms;

  modport source (output valid, action, conn_id, now_ms, input ready);
  modport sink (input valid, action, conn_id, now_ms, output ready);
endinterface

interface hbt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] expired_id;
  logic        reason;
  logic        table_full;
  logic [4:0]  live_total;
  logic        last;

  modport source (output valid, kind, expired_id, reason, table_full, live_total, last,
                  input ready);
  modport sink (input valid, kind, expired_id, reason, table_full, live_total, last,
                output ready);
endinterface

// ----- sv/hbt_front.sv -----
module hbt_front (
  input  logic                clk,
  input  logic                rst,
  hbt_req_if.sink             req,
  output hbt_pkg::item_head_t head,
  input  logic                pop
);
  import hbt_pkg::*;

  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  item_t      incoming;

  assign req.ready = (fill != 2'd2);
  assign push      = req.valid && req.ready;

  always_comb begin
    incoming.action  = action_t'(req.action);
    incoming.is_tick = (req.action == ACT_TICK);
    incoming.conn_id = req.conn_id;
    incoming.now_ms  = req.now_ms;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= incoming;
  end

  assign head.valid = (fill != 2'd0);
  assign head.item  = q[rd_ptr];

endmodule

// ----- sv/hbt_back.sv -----
module hbt_back #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  hbt_pkg::item_head_t          head,
  output logic                         pop,
  input  logic [hbt_pkg::LIMIT_W-1:0]  hb_limit,
  input  logic [hbt_pkg::LIMIT_W-1:0]  idle_limit,
  hbt_rsp_if.source                    rsp
);
  import hbt_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                 state, state_next;
  logic [TABLE_DEPTH-1:0] slot_valid, valid_next;
  logic [ID_W-1:0]        slot_id   [TABLE_DEPTH];
  logic [MS_W-1:0]        slot_last [TABLE_DEPTH];
  logic [CW-1:0]          live_cnt, live_next;
  logic [IW-1:0]          scan_idx, idx_next;
  logic [MS_W-1:0]        tick_now;
  result_t                res, res_next;
  logic                   out_valid;

  logic [TABLE_DEPTH-1:0] match, free, first_free, touch, alloc;
  logic                   out_free, emit;
  logic [MS_W-1:0]        diff;
  logic                   hb_exp, idle_exp, expire;

  function automatic logic [LIVE_W-1:0] live5(input logic [CW-1:0] n);
    logic [CW+LIVE_W-1:0] ext;
    ext = (CW+LIVE_W)'(n);
    return ext[LIVE_W-1:0];
  endfunction

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match[i] = slot_valid[i] && (slot_id[i] == head.item.conn_id);
    end
  end

  assign free       = ~slot_valid;
  assign first_free = free & (~free + TABLE_DEPTH'(1));
  assign out_free   = !out_valid || rsp.ready;

  assign diff     = tick_now - slot_last[scan_idx];
  assign hb_exp   = $signed(diff) > $signed({1'b0, hb_limit});
  assign idle_exp = (idle_limit != '0) && ($signed(diff) > $signed({1'b0, idle_limit}));
  assign expire   = slot_valid[scan_idx] && (hb_exp || idle_exp);

  always_comb begin
    state_next = state;
    valid_next = slot_valid;
    live_next  = live_cnt;
    idx_next   = scan_idx;
    touch      = '0;
    alloc      = '0;
    emit       = 1'b0;
    pop        = 1'b0;
    res_next   = '0;
    unique case (state)
      S_IDLE: begin
        if (head.valid && out_free) begin
          pop = 1'b1;
          if (head.item.is_tick) begin
            state_next = S_SCAN;
            idx_next   = '0;
          end else begin
            emit          = 1'b1;
            res_next.kind = KIND_ACK;
            res_next.last = 1'b1;
            case (head.item.action)
              ACT_REGISTER: begin
                if (|match) begin
                  touch = match;
                end else if (|free) begin
                  alloc      = first_free;
                  valid_next = slot_valid | first_free;
                  live_next  = live_cnt + CW'(1);
                end else begin
                  res_next.table_full = 1'b1;
                end
              end
              ACT_UNREGISTER: begin
                valid_next = slot_valid & ~match;
                if (|match) live_next = live_cnt - CW'(1);
              end
              ACT_ACTIVITY: touch = match;
              default: ;
            endcase
            res_next.live_total = live5(live_next);
          end
        end
      end
      S_SCAN: begin
        if (out_free) begin
          if (expire) begin
            valid_next[scan_idx] = 1'b0;
            live_next            = live_cnt - CW'(1);
            emit                 = 1'b1;
            res_next.kind        = KIND_EXPIRED;
            res_next.expired_id  = slot_id[scan_idx];
            res_next.reason      = hb_exp ? REASON_HB_LOST : REASON_IDLE;
            res_next.live_total  = live5(live_next);
          end
          if (scan_idx == LAST_IDX) state_next = S_DONE;
          else idx_next = scan_idx + IW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit                = 1'b1;
          res_next.kind       = KIND_DONE;
          res_next.live_total = live5(live_cnt);
          res_next.last       = 1'b1;
          state_next          = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      live_cnt   <= '0;
      scan_idx   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      slot_valid <= valid_next;
      live_cnt   <= live_next;
      scan_idx   <= idx_next;
      if (emit) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) res <= res_next;
    if (pop && head.item.is_tick) tick_now <= head.item.now_ms;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (touch[i] || alloc[i]) slot_last[i] <= head.item.now_ms;
      if (alloc[i]) slot_id[i] <= head.item.conn_id;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.kind       = res.kind;
  assign rsp.expired_id = res.expired_id;
  assign rsp.reason     = res.reason;
  assign rsp.table_full = res.table_full;
  assign rsp.live_total = res.live_total;
  assign rsp.last       = res.last;

endmodule

// ----- sv/heartbeat_timeout_table_unit.sv -----
// Channel  Dir  Payload                                                   Transfer
// req      in   action, conn_id, now_ms                                   valid & ready
// rsp      out  kind, expired_id, reason, table_full, live_total, last   valid & ready
// cfg      in   cfg_index, cfg_data                                       cfg_we
//
// Register, unregister and activity are handled in the table engine by a parallel id match.
// A tick scans one slot per cycle while the result register is free, then gives the finish result.
// A 2-entry input queue keeps req taking transfers, until it is full, while the engine works or rsp stalls.
// rsp stall holds the engine; the result register frees again on the transfer.
// Reset empties the table and the queue and loads the default limits.
module heartbeat_timeout_table_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  hbt_req_if.sink                     req,
  hbt_rsp_if.source                   rsp,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [hbt_pkg::LIMIT_W-1:0] cfg_data
);
  import hbt_pkg::*;

  logic [LIMIT_W-1:0] hb_limit;
  logic [LIMIT_W-1:0] idle_limit;
  item_head_t         head;
  logic               pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      hb_limit   <= LIMIT_W'(30000);
      idle_limit <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEARTBEAT: hb_limit   <= cfg_data;
        CFG_IDLE:      idle_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  hbt_front u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .head (head),
    .pop  (pop)
  );

  hbt_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .hb_limit   (hb_limit),
    .idle_limit (idle_limit),
    .rsp        (rsp)
  );

  a_full_is_ack: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.table_full |-> (rsp.kind == KIND_ACK) && rsp.last)
    else $error("table_full on a non-acknowledge result");

  a_expired_not_last: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.kind == KIND_EXPIRED) |-> !rsp.last)
    else $error("expired record marked last");

  a_id_only_expired: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.kind != KIND_EXPIRED) |->
      (rsp.expired_id == '0) && (rsp.reason == REASON_HB_LOST))
    else $error("id or reason set outside an expired record");

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (7'(rsp.live_total) <= 7'(TABLE_DEPTH)))
    else $error("live count above table depth");

endmodule
